[hdl/assert_macros.svh]
// Assertion macros for the time-to-collision brake RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define TCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TCB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/tcb_pkg.sv]
// Shared types, constants and the cosine table of the time-to-collision brake.
`default_nettype none
package tcb_pkg;

    localparam int BEAM_COUNT      = 1080;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int BEAM_POS_W      = $clog2(BEAM_COUNT + 1);
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int COS_MUL_W       = 15 + $clog2(COS_TABLE_DEPTH + 1);
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] TTC_THRESHOLD_RST = 16'd1500;
    localparam logic [15:0] RANGE_MIN_RST     = 16'd0;
    localparam logic [15:0] RANGE_MAX_RST     = 16'd30000;
    localparam logic [15:0] ANGLE_START_RST   = 16'hA000;
    localparam logic [9:0]  ANGLE_STEP_RST    = 10'd46;
    localparam logic [9:0]  RANGE_SCALE       = 10'd1000;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic {
        CMD_VELOCITY = 1'b0,
        CMD_RANGE    = 1'b1
    } cmd_e_t;

    typedef enum logic [2:0] {
        REG_TTC_THRESHOLD = 3'd0,
        REG_RANGE_MIN     = 3'd1,
        REG_RANGE_MAX     = 3'd2,
        REG_ANGLE_START   = 3'd3,
        REG_ANGLE_STEP    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] ttc_threshold_ms;
        logic [15:0] valid_range_min_mm;
        logic [15:0] valid_range_max_mm;
        logic [15:0] angle_start;
        logic [9:0]  angle_step;
    } cfg_t;

    // One queued job: a speed update, or a beam to test and/or a scan end.
    typedef struct packed {
        cmd_e_t      kind;
        logic [15:0] data;
        logic [15:0] angle;
        logic        test;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef logic [14:0] cos_rom_t [COS_TABLE_DEPTH];

    // Quarter-wave cosine in Q1.15, from a Q30 Taylor series evaluated in Horner form.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   c;
        longint unsigned   p;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            x  = (HALF_PI_Q30 * longint'(k)) / COS_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            c  = Q30_ONE;
            p  = ((x2 * c) >> 30) / 132;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            p  = ((x2 * c) >> 30) / 90;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            p  = ((x2 * c) >> 30) / 56;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            p  = ((x2 * c) >> 30) / 30;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            p  = ((x2 * c) >> 30) / 12;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            p  = ((x2 * c) >> 30) / 2;
            c  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            c  = (c * 64'd32767 + 64'd536870912) >> 30;
            if (c > 64'd32767)
            begin
                c = 64'd32767;
            end
            rom[k] = c[14:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage
`default_nettype wire

[hdl/time_to_collision_brake_core.sv]
// Time-to-collision brake core: configuration registers, front end, queue and back end.
// A tested beam holds the back end for a pop and table read, two multiplier passes and a
// compare; a speed update needs only the pop, and a skipped beam that ends a scan the pop
// and the compare. Other skipped beams never enter the queue. Items are accepted while the
// 2-entry queue has room; a scan end's brake flag is registered at its compare, which waits
// until the previous result is taken. Reset clears all scan state and loads register defaults.
`default_nettype none
`include "assert_macros.svh"
module time_to_collision_brake_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        command,
    input  wire logic [15:0] velocity_mm_s,
    input  wire logic [15:0] range_mm,
    input  wire logic        scan_last,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             brake
);

    tcb_pkg::cfg_t    cfg_reg;
    tcb_pkg::cfg_t    cfg_next;
    tcb_pkg::q_stat_t q_stat;
    tcb_pkg::entry_t  q_entry;
    tcb_pkg::entry_t  q_head;
    logic             q_push;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (tcb_pkg::reg_idx_t'(cfg_index))
                tcb_pkg::REG_TTC_THRESHOLD: cfg_next.ttc_threshold_ms   = cfg_data;
                tcb_pkg::REG_RANGE_MIN:     cfg_next.valid_range_min_mm = cfg_data;
                tcb_pkg::REG_RANGE_MAX:     cfg_next.valid_range_max_mm = cfg_data;
                tcb_pkg::REG_ANGLE_START:   cfg_next.angle_start        = cfg_data;
                tcb_pkg::REG_ANGLE_STEP:    cfg_next.angle_step         = cfg_data[9:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ttc_threshold_ms   <= tcb_pkg::TTC_THRESHOLD_RST;
            cfg_reg.valid_range_min_mm <= tcb_pkg::RANGE_MIN_RST;
            cfg_reg.valid_range_max_mm <= tcb_pkg::RANGE_MAX_RST;
            cfg_reg.angle_start        <= tcb_pkg::ANGLE_START_RST;
            cfg_reg.angle_step         <= tcb_pkg::ANGLE_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .velocity_mm_s (velocity_mm_s),
        .range_mm      (range_mm),
        .scan_last     (scan_last),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    tcb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_entry),
        .pop   (q_pop),
        .rdata (q_head),
        .stat  (q_stat)
    );

    tcb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .brake        (brake)
    );

    `TCB_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_stat.full)
    `TCB_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_stat.empty)
    `TCB_ASSERT_NXT(a_empty_holds, clk, rst_n, q_stat.empty && !q_push, q_stat.empty)

endmodule
`default_nettype wire

[hdl/tcb_front.sv]
// Front end: accepts items, tracks beam position and angle, queues work.
`default_nettype none
module tcb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcb_pkg::cfg_t   cfg,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire logic            command,
    input  wire logic [15:0]     velocity_mm_s,
    input  wire logic [15:0]     range_mm,
    input  wire logic            scan_last,
    input  wire tcb_pkg::q_stat_t q_stat,
    output logic                 q_push,
    output tcb_pkg::entry_t      q_entry
);

    logic [tcb_pkg::BEAM_POS_W-1:0] beam_pos_reg;
    logic [tcb_pkg::BEAM_POS_W-1:0] beam_pos_next;
    logic [15:0]                    angle_reg;
    logic [15:0]                    angle_next;
    logic                           accept;
    logic                           is_range;
    logic                           in_scan;
    logic                           in_window;

    assign item_ready = !q_stat.full;
    assign accept     = item_valid && item_ready;
    assign is_range   = (command == tcb_pkg::CMD_RANGE);
    assign in_scan    = beam_pos_reg < tcb_pkg::BEAM_POS_W'(tcb_pkg::BEAM_COUNT);
    assign in_window  = (range_mm >= cfg.valid_range_min_mm)
                     && (range_mm <= cfg.valid_range_max_mm);

    always_comb
    begin
        q_entry.kind  = is_range ? tcb_pkg::CMD_RANGE : tcb_pkg::CMD_VELOCITY;
        q_entry.data  = is_range ? range_mm : velocity_mm_s;
        q_entry.angle = angle_reg;
        q_entry.test  = is_range && in_scan && in_window;
        q_entry.last  = is_range && scan_last;
    end

    // Skipped beams that do not end a scan need no work downstream.
    assign q_push = accept && (!is_range || q_entry.test || q_entry.last);

    always_comb
    begin
        beam_pos_next = beam_pos_reg;
        angle_next    = angle_reg;
        if (accept && is_range)
        begin
            if (scan_last)
            begin
                beam_pos_next = '0;
                angle_next    = cfg.angle_start;
            end
            else if (in_scan)
            begin
                beam_pos_next = beam_pos_reg + 1'b1;
                angle_next    = angle_reg + {6'd0, cfg.angle_step};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_pos_reg <= '0;
            angle_reg    <= tcb_pkg::ANGLE_START_RST;
        end
        else
        begin
            beam_pos_reg <= beam_pos_next;
            angle_reg    <= angle_next;
        end
    end

endmodule
`default_nettype wire

[hdl/tcb_queue.sv]
// Short job queue between the front end and the back end.
`default_nettype none
module tcb_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tcb_pkg::entry_t  wdata,
    input  wire logic             pop,
    output tcb_pkg::entry_t       rdata,
    output tcb_pkg::q_stat_t      stat
);

    tcb_pkg::entry_t               mem_reg [tcb_pkg::Q_DEPTH];
    logic [tcb_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [tcb_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [tcb_pkg::Q_CNT_W-1:0]   count_reg;
    logic [tcb_pkg::Q_CNT_W-1:0]   count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == tcb_pkg::Q_CNT_W'(tcb_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tcb_pkg::Q_PTR_W'(tcb_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tcb_pkg::Q_PTR_W'(tcb_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/tcb_back.sv]
// Back end: cosine lookup, shared multiplier, time-to-collision test and brake result.
`default_nettype none
module tcb_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tcb_pkg::cfg_t    cfg,
    input  wire tcb_pkg::q_stat_t q_stat,
    input  wire tcb_pkg::entry_t  q_head,
    output logic                  q_pop,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output logic                  brake
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROJ   = 4'b0010,
        S_SCALE  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [15:0]                     speed_reg;
    logic [15:0]                     speed_next;
    logic                            unsafe_reg;
    logic                            unsafe_next;
    logic                            result_valid_reg;
    logic                            result_valid_next;
    logic                            brake_reg;
    logic                            brake_next;

    logic [15:0]                     range_reg;
    logic                            test_reg;
    logic                            last_reg;
    logic [14:0]                     rom_q_reg;
    logic                            rom_zero_reg;
    logic                            rom_neg_reg;
    logic signed [33:0]              prod_reg;
    logic [25:0]                     r1000_reg;

    logic [1:0]                      quad;
    logic [13:0]                     offs;
    logic [14:0]                     u;
    logic [tcb_pkg::COS_MUL_W-1:0]   idx_full;
    logic [tcb_pkg::COS_MUL_W-15:0]  idx_hi;
    logic                            idx_ok;
    logic [tcb_pkg::COS_IDX_W-1:0]   rom_addr;
    logic [15:0]                     cos_mag;
    logic signed [15:0]              cos_val;
    logic                            prod_pos;
    logic [14:0]                     proj;
    logic signed [16:0]              mul_a;
    logic signed [16:0]              mul_b;
    logic                            hit;
    logic                            take;

    // Fold the angle onto the quarter-wave table: odd quadrants mirror, middle two negate.
    assign quad     = q_head.angle[15:14];
    assign offs     = q_head.angle[13:0];
    assign u        = quad[0] ? 15'(15'd16384 - {1'b0, offs}) : {1'b0, offs};
    assign idx_full = tcb_pkg::COS_MUL_W'(u)
                    * tcb_pkg::COS_MUL_W'(tcb_pkg::COS_TABLE_DEPTH);
    assign idx_hi   = idx_full[tcb_pkg::COS_MUL_W-1:14];
    assign idx_ok   = idx_hi < tcb_pkg::COS_TABLE_DEPTH;
    assign rom_addr = idx_ok ? idx_hi[tcb_pkg::COS_IDX_W-1:0] : '0;

    assign cos_mag  = rom_zero_reg ? 16'd0 : {1'b0, rom_q_reg};
    assign cos_val  = rom_neg_reg ? 16'(-cos_mag) : cos_mag;

    assign prod_pos = !prod_reg[33] && (prod_reg != '0);
    assign proj     = prod_pos ? prod_reg[29:15] : 15'd0;

    // One multiplier: speed times cosine, then threshold times projected speed.
    assign mul_a = (state_reg == S_PROJ) ? {speed_reg[15], speed_reg}
                                         : {1'b0, cfg.ttc_threshold_ms};
    assign mul_b = (state_reg == S_PROJ) ? {cos_val[15], cos_val} : {2'b00, proj};

    assign hit  = unsafe_reg || (test_reg && ({8'd0, r1000_reg} < prod_reg[33:0]));
    assign take = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        speed_next        = speed_reg;
        unsafe_next       = unsafe_reg;
        result_valid_next = result_valid_reg && !result_ready;
        brake_next        = brake_reg;
        q_pop             = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == tcb_pkg::CMD_VELOCITY)
                    begin
                        speed_next = q_head.data;
                    end
                    else if (q_head.test)
                    begin
                        state_next = S_PROJ;
                    end
                    else if (q_head.last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_PROJ:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!last_reg)
                begin
                    unsafe_next = hit;
                    state_next  = S_IDLE;
                end
                else if (take)
                begin
                    result_valid_next = 1'b1;
                    brake_next        = hit;
                    unsafe_next       = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            speed_reg        <= '0;
            unsafe_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            brake_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            speed_reg        <= speed_next;
            unsafe_reg       <= unsafe_next;
            result_valid_reg <= result_valid_next;
            brake_reg        <= brake_next;
        end
    end

    // Datapath registers; the cosine table read is registered like a memory port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            range_reg    <= q_head.data;
            test_reg     <= q_head.test;
            last_reg     <= q_head.last;
            rom_q_reg    <= tcb_pkg::COS_ROM[rom_addr];
            rom_zero_reg <= !idx_ok;
            rom_neg_reg  <= quad[0] ^ quad[1];
        end
        if ((state_reg == S_PROJ) || (state_reg == S_SCALE))
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == S_SCALE)
        begin
            r1000_reg <= range_reg * tcb_pkg::RANGE_SCALE;
        end
    end

    assign result_valid = result_valid_reg;
    assign brake        = brake_reg;

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the time-to-collision brake core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MS_PER_S     = 1000;
    localparam int QUARTER_TURN = 16384;
    localparam int Q15_MAX      = 32767;
    localparam int LATENCY_PAD  = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 80;
    localparam int PHASE_ITEMS  = 20;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        tcb_pkg::cmd_e_t cmd;
        logic [15:0]     vel;
        logic [15:0]     rng;
        logic            last;
    } scan_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        command = 1'b0;
    logic [15:0] velocity_mm_s = '0;
    logic [15:0] range_mm = '0;
    logic        scan_last = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        brake;

    // Register copy and scan state of the predictor, at their reset values.
    logic [15:0]        thr_ms = 16'd1500;
    logic [15:0]        lo_mm = 16'd0;
    logic [15:0]        hi_mm = 16'd30000;
    logic [15:0]        start_ang = 16'hA000;
    logic [9:0]         step_ang = 10'd46;
    logic signed [15:0] held_speed = '0;
    logic [10:0]        beam_idx = '0;
    logic [15:0]        sweep_angle = 16'hA000;
    logic               hazard = 1'b0;

    int         cos_tab [tcb_pkg::COS_TABLE_DEPTH];
    logic       brake_due [$];
    scan_item_t item_feed [$];
    int         fed_count = 0;
    int         bad_count = 0;
    int         tx_wait = 0;
    int         rx_wait = 0;
    bit         tx_idle_on = 1'b1;
    bit         rx_idle_on = 1'b1;
    logic       rx_hold = 1'b0;
    bit         item_taken = 1'b0;
    bit         res_taken = 1'b0;
    event       stall_kick;

    time_to_collision_brake_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .velocity_mm_s (velocity_mm_s),
        .range_mm      (range_mm),
        .scan_last     (scan_last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .brake         (brake)
    );

    // Quarter-wave table: Q30 Taylor series in Horner form, then scaled to Q1.15.
    function automatic void fill_cos_table();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned c;
        longint unsigned p;
        int unsigned     divs [6] = '{132, 90, 56, 30, 12, 2};
        for (int k = 0; k < tcb_pkg::COS_TABLE_DEPTH; k++)
        begin
            x  = (tcb_pkg::HALF_PI_Q30 * longint'(k)) / tcb_pkg::COS_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            c  = tcb_pkg::Q30_ONE;
            foreach (divs[j])
            begin
                p = ((x2 * c) >> 30) / divs[j];
                c = (p >= tcb_pkg::Q30_ONE) ? 64'd0 : tcb_pkg::Q30_ONE - p;
            end
            c = (c * Q15_MAX + (64'd1 << 29)) >> 30;
            if (c > Q15_MAX)
                c = Q15_MAX;
            cos_tab[k] = int'(c);
        end
    endfunction

    function automatic int cos_at(int unsigned u);
        int unsigned i;
        i = (u * tcb_pkg::COS_TABLE_DEPTH) >> 14;
        if (i >= tcb_pkg::COS_TABLE_DEPTH)
            return 0;
        return cos_tab[i];
    endfunction

    function automatic int quarter_cos(logic [15:0] a);
        int unsigned p;
        p = a[13:0];
        case (a[15:14])
            2'd0:    return cos_at(p);
            2'd1:    return -cos_at(QUARTER_TURN - p);
            2'd2:    return -cos_at(p);
            default: return cos_at(QUARTER_TURN - p);
        endcase
    endfunction

    // Advances the scan by one accepted item; a scan end queues its brake flag.
    function automatic void predict_brake(tcb_pkg::cmd_e_t cmd, logic [15:0] vel,
                                          logic [15:0] rng, logic last);
        longint prod;
        longint proj;
        if (cmd == tcb_pkg::CMD_VELOCITY)
            held_speed = vel;
        else
        begin
            if (beam_idx < tcb_pkg::BEAM_COUNT)
            begin
                if (rng >= lo_mm && rng <= hi_mm)
                begin
                    prod = longint'(held_speed) * quarter_cos(sweep_angle);
                    proj = prod >>> 15;
                    if (prod > 0 && proj > 0 &&
                        longint'(rng) * MS_PER_S < longint'(thr_ms) * proj)
                        hazard = 1'b1;
                end
                beam_idx    = beam_idx + 11'd1;
                sweep_angle = sweep_angle + 16'(step_ang);
            end
            if (last)
            begin
                brake_due.push_back(hazard);
                beam_idx    = '0;
                sweep_angle = start_ang;
                hazard      = 1'b0;
            end
        end
    endfunction

    function automatic void log_mismatch(string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic int idle_draw(bit en);
        return en ? int'($urandom_range(0, 3)) : 0;
    endfunction

    function automatic void add_speed(logic [15:0] v, logic last);
        scan_item_t it;
        it.cmd  = tcb_pkg::CMD_VELOCITY;
        it.vel  = v;
        it.rng  = 16'($urandom);
        it.last = last;
        item_feed.push_back(it);
        fed_count++;
    endfunction

    function automatic void add_beam(logic [15:0] r, logic last);
        scan_item_t it;
        it.cmd  = tcb_pkg::CMD_RANGE;
        it.vel  = 16'($urandom);
        it.rng  = r;
        it.last = last;
        item_feed.push_back(it);
        fed_count++;
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 3));
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(2000, 32767));
        endcase
    endfunction

    // Window edges, short ranges that tend to trip the brake, and the full field.
    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return lo_mm + 16'($urandom_range(0, 3)) - 16'd1;
            4:       return hi_mm - 16'($urandom_range(0, 3)) + 16'd1;
            5, 6, 7: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_scan(int beams, bit close);
        for (int b = 0; b < beams; b++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_speed(pick_speed(), 1'($urandom));
            add_beam(pick_range(), close && b == beams - 1);
        end
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 12);
        if (r < 19)
            return $urandom_range(13, 60);
        return $urandom_range(61, 200);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tcb_pkg::REG_TTC_THRESHOLD: thr_ms = val;
            tcb_pkg::REG_RANGE_MIN:     lo_mm = val;
            tcb_pkg::REG_RANGE_MAX:     hi_mm = val;
            tcb_pkg::REG_ANGLE_START:   start_ang = val;
            tcb_pkg::REG_ANGLE_STEP:    step_ang = val[9:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every item is taken and every flag is back, then lets the back end drain.
    task automatic settle(int limit);
        for (int n = 0; n < limit &&
             (item_feed.size() != 0 || item_valid || brake_due.size() != 0); n++)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic random_setting();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom);
            default: v = 16'($urandom_range(300, 4000));
        endcase
        write_reg(tcb_pkg::REG_TTC_THRESHOLD, v);
        case ($urandom_range(0, 7))
            0:       v = 16'hFFFF;
            1:       v = 16'($urandom);
            default: v = 16'($urandom_range(0, 1500));
        endcase
        write_reg(tcb_pkg::REG_RANGE_MIN, v);
        case ($urandom_range(0, 7))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom);
            default: v = 16'($urandom_range(8000, 65535));
        endcase
        write_reg(tcb_pkg::REG_RANGE_MAX, v);
        write_reg(tcb_pkg::REG_ANGLE_START, 16'($urandom));
        case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'h03FF;
            default: v = 16'($urandom);
        endcase
        write_reg(tcb_pkg::REG_ANGLE_STEP, v);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb NOT OK");
        $finish;
    end

    always @(negedge clk)
    begin : drive_items
        scan_item_t nxt;
        if (!(item_valid && !item_taken))
        begin
            if (item_valid)
                tx_wait = idle_draw(tx_idle_on);
            if (tx_wait > 0)
            begin
                item_valid <= 1'b0;
                tx_wait--;
            end
            else if (item_feed.size() != 0)
            begin
                nxt = item_feed.pop_front();
                command       <= nxt.cmd;
                velocity_mm_s <= nxt.vel;
                range_mm      <= nxt.rng;
                scan_last     <= nxt.last;
                item_valid    <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (res_taken)
            rx_wait = idle_draw(rx_idle_on);
        if (rx_hold)
            result_ready <= 1'b0;
        else if (rx_wait > 0)
        begin
            result_ready <= 1'b0;
            rx_wait--;
        end
        else
            result_ready <= 1'b1;
    end

    // Long receiver stall so the queue fills and the block refuses input.
    initial
    begin
        forever
        begin
            @(stall_kick);
            @(negedge clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        logic want;
        item_taken = rst_n && item_valid && item_ready;
        res_taken  = rst_n && result_valid && result_ready;
        if (item_taken)
            predict_brake(tcb_pkg::cmd_e_t'(command), velocity_mm_s, range_mm, scan_last);
        if (res_taken)
        begin
            if (brake_due.size() == 0)
                log_mismatch($sformatf("brake item %0b with no scan end pending", brake));
            else
            begin
                want = brake_due.pop_front();
                if (brake !== want)
                    log_mismatch($sformatf("brake mismatch: expected %0b, got %0b",
                                           want, brake));
            end
        end
    end

    initial
    begin : stimulus
        int phase_end;
        int random_end;
        fill_cos_table();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: scan_last on a speed update is ignored, out-of-window range,
        // and reversing toward a rear beam, which gives a positive projection.
        add_speed(16'h7FFF, 1'b1);
        add_beam(16'd0, 1'b0);
        add_beam(16'hFFFF, 1'b1);
        add_speed(16'h8000, 1'b0);
        add_beam(16'd100, 1'b1);
        settle(DRAIN_LIMIT);

        write_reg(tcb_pkg::REG_TTC_THRESHOLD, 16'd1000);
        write_reg(tcb_pkg::REG_RANGE_MIN, 16'd0);
        write_reg(tcb_pkg::REG_RANGE_MAX, 16'hFFFF);
        write_reg(tcb_pkg::REG_ANGLE_START, 16'd0);
        write_reg(tcb_pkg::REG_ANGLE_STEP, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        // The first scan after the write still starts at the old angle.
        add_speed(16'h7FFF, 1'b0);
        add_beam(16'd0, 1'b1);
        // Exactly on the threshold is safe, one millimeter closer is not.
        add_beam(16'd32766, 1'b1);
        add_beam(16'd32765, 1'b1);
        // A projection that rounds down to zero, is zero or is negative never brakes.
        add_speed(16'd1, 1'b0);
        add_beam(16'd0, 1'b1);
        add_speed(16'd0, 1'b0);
        add_beam(16'd0, 1'b1);
        add_speed(16'hFFFF, 1'b0);
        add_beam(16'd0, 1'b1);
        settle(DRAIN_LIMIT);

        // An empty window: min above max.
        write_reg(tcb_pkg::REG_RANGE_MIN, 16'd5000);
        write_reg(tcb_pkg::REG_RANGE_MAX, 16'd4000);
        add_speed(16'h7FFF, 1'b0);
        add_beam(16'd4500, 1'b0);
        add_beam(16'd0, 1'b1);
        settle(DRAIN_LIMIT);

        write_reg(tcb_pkg::REG_TTC_THRESHOLD, 16'hFFFF);
        write_reg(tcb_pkg::REG_RANGE_MIN, 16'hFFFF);
        write_reg(tcb_pkg::REG_RANGE_MAX, 16'hFFFF);
        write_reg(tcb_pkg::REG_ANGLE_START, 16'h8000);
        write_reg(tcb_pkg::REG_ANGLE_STEP, 16'h03FF);
        add_beam(16'hFFFF, 1'b0);
        add_beam(16'hFFFF, 1'b1);
        settle(DRAIN_LIMIT);
        write_reg(tcb_pkg::REG_TTC_THRESHOLD, 16'd0);
        add_speed(16'h8000, 1'b0);
        add_beam(16'hFFFF, 1'b1);
        settle(DRAIN_LIMIT);

        // One scan longer than the beam count: beams past the count must not brake.
        write_reg(tcb_pkg::REG_TTC_THRESHOLD, 16'd1500);
        write_reg(tcb_pkg::REG_RANGE_MIN, 16'd0);
        write_reg(tcb_pkg::REG_RANGE_MAX, 16'hFFFF);
        write_reg(tcb_pkg::REG_ANGLE_START, 16'd0);
        write_reg(tcb_pkg::REG_ANGLE_STEP, 16'd0);
        tx_idle_on = 1'b0;
        add_speed(16'd20000, 1'b0);
        add_beam(16'hFFFF, 1'b1);
        for (int b = 0; b < tcb_pkg::BEAM_COUNT; b++)
        begin
            if (b == tcb_pkg::BEAM_COUNT / 2)
                add_speed(16'd20000, 1'b0);
            add_beam(16'($urandom_range(40000, 65535)), 1'b0);
        end
        add_speed(16'd30000, 1'b0);
        for (int b = 0; b < 6; b++)
            add_beam(16'($urandom_range(0, 100)), 1'b0);
        add_beam(16'd0, 1'b1);
        settle(DRAIN_LIMIT * 4);

        random_end = fed_count + RANDOM_ITEMS;
        while (fed_count < random_end)
        begin
            random_setting();
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            phase_end = fed_count + PHASE_ITEMS;
            while (fed_count < phase_end)
                queue_scan(pick_len(), 1'b1);
            // Sometimes leave a scan open so the next settings land mid-scan.
            if ($urandom_range(0, 3) == 0)
                queue_scan($urandom_range(1, 8), 1'b0);
            settle(DRAIN_LIMIT * 4);
        end

        // Every beam ends a scan while the receiver stalls.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        @(posedge clk);
        -> stall_kick;
        for (int s = 0; s < 60; s++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_speed(pick_speed(), 1'($urandom));
            add_beam(pick_range(), 1'b1);
        end
        settle(DRAIN_LIMIT * 4);

        if (brake_due.size() != 0)
            log_mismatch($sformatf("%0d brake flags never arrived", brake_due.size()));
        if (bad_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[time_to_collision_brake_core.f]
+incdir+hdl
hdl/tcb_pkg.sv
hdl/tcb_front.sv
hdl/tcb_queue.sv
hdl/tcb_back.sv
hdl/time_to_collision_brake_core.sv
test/tb.sv
